// ----- sv/iokc_pkg.sv -----
// iokc_pkg: shared types and constants of the insertion-order key cache
// holds the word structs of both channels, the action codes and the fsm states
// depends on nothing
package iokc_pkg;

    localparam int IOKC_CAPACITY   = 64;
    localparam int IOKC_KEY_BITS   = 64;
    localparam int IOKC_VALUE_BITS = 32;

    typedef enum logic [1:0] {
        ACT_INSERT     = 2'd0,
        ACT_LOOKUP     = 2'd1,
        ACT_INVALIDATE = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] value_out;
        logic        evicted;
        logic [63:0] evicted_key;
        logic [6:0]  occupancy;
    } t_out_word;

    // update strobes broadcast to every cell
    typedef struct packed {
        logic ins;
        logic inv;
    } t_cell_ctl;

endpackage

// ----- sv/iokc_cell.sv -----
// iokc_cell: one entry of the cache chain, with its own key compare
// takes from its left neighbour on insert, from its right on invalidate
// depends on iokc_pkg
module iokc_cell
    import iokc_pkg::*;
#(
    parameter int KEY_BITS   = IOKC_KEY_BITS,
    parameter int VALUE_BITS = IOKC_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    input  logic                  i_left_valid,
    input  logic [KEY_BITS-1:0]   i_left_key,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic                  i_right_valid,
    input  logic [KEY_BITS-1:0]   i_right_key,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_match,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_take_left;
    logic                  w_take_right;

    assign o_match = r_valid && (r_key == i_cmp_key);
    assign o_seen  = i_seen || o_match;

    // insert: every cell up to and including the hit moves back one place
    assign w_take_left  = i_ctl.ins && !i_seen;
    // invalidate: the hit and every cell after it move forward one place
    assign w_take_right = i_ctl.inv && o_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take_left) begin
            r_valid <= i_left_valid;
        end else if (w_take_right) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_left) begin
            r_key   <= i_left_key;
            r_value <= i_left_value;
        end else if (w_take_right) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ----- sv/insertion_order_key_cache.sv -----
// insertion_order_key_cache: top level of the fully associative key cache
// instantiates a row of iokc_cell entries kept newest first
// depends on iokc_pkg and iokc_cell
//
// usage
//   input channel: i_in_valid / o_in_ready carry one t_in_word (action, key, value)
//   output channel: o_out_valid / i_out_ready carry one t_out_word per input word
//   a word is taken into the request register in the idle state and executed in the
//   execute state, which holds while a waiting result is not taken; the result is
//   registered at the end of the execute cycle, which raises o_out_valid, and the
//   result word can be taken from then on
//   a new word is taken only in the idle state, so it waits until the last one has
//   executed; in the single execute cycle every cell compares and shifts at once
//   cell 0 holds the newest entry; an insert shifts cells back, an invalidate
//   closes the gap by shifting the older cells forward, a lookup changes nothing
//   a result register parts the two channels: a new word is taken while a result
//   still waits; if the receiver stalls, execution holds until the register frees
//   reset (synchronous, active low) clears every valid bit and the entry count;
//   stored keys and values need no clearing
module insertion_order_key_cache
    import iokc_pkg::*;
#(
    parameter int CAPACITY   = IOKC_CAPACITY,
    parameter int KEY_BITS   = IOKC_KEY_BITS,
    parameter int VALUE_BITS = IOKC_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state         r_state;
    t_state         n_state;
    t_in_word       r_req;
    t_out_word      r_out;
    t_out_word      n_out;
    logic           r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic           w_exec;
    logic           w_accept;
    t_cell_ctl      w_ctl;

    logic [KEY_BITS-1:0]   w_cmp_key;
    logic [63:0]           w_val_ext;
    logic [VALUE_BITS-1:0] w_new_val;

    // chain wiring between neighbouring cells
    logic [CAPACITY:0]     w_seen;
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY-1:0]   w_cv;
    logic [KEY_BITS-1:0]   w_ck  [CAPACITY];
    logic [VALUE_BITS-1:0] w_cval[CAPACITY];

    logic                  w_hit;
    logic                  w_full;
    logic [VALUE_BITS-1:0] w_hit_val;
    logic [63:0]           w_hit_val_ext;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_cmp_key = r_req.key[KEY_BITS-1:0];
    assign w_val_ext = {32'd0, r_req.value};
    assign w_new_val = w_val_ext[VALUE_BITS-1:0];
    assign w_seen[0] = 1'b0;

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_exec     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: w_exec     = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_exec     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    // update strobes to the cells, only in the execute cycle
    always_comb begin
        w_ctl = '0;
        if (w_exec) begin
            case (t_action'(r_req.action))
                ACT_INSERT:     w_ctl.ins = 1'b1;
                ACT_INVALIDATE: w_ctl.inv = 1'b1;
                default:        w_ctl     = '0;
            endcase
        end
    end

    // ---------------------------------------------------------------- cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                  w_lv;
        logic [KEY_BITS-1:0]   w_lk;
        logic [VALUE_BITS-1:0] w_lval;
        logic                  w_rv;
        logic [KEY_BITS-1:0]   w_rk;
        logic [VALUE_BITS-1:0] w_rval;

        if (g == 0) begin : g_head
            // the new entry enters at the front
            assign w_lv   = 1'b1;
            assign w_lk   = w_cmp_key;
            assign w_lval = w_new_val;
        end else begin : g_body_l
            assign w_lv   = w_cv[g-1];
            assign w_lk   = w_ck[g-1];
            assign w_lval = w_cval[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            // an empty entry enters at the back on invalidate
            assign w_rv   = 1'b0;
            assign w_rk   = w_ck[g];
            assign w_rval = w_cval[g];
        end else begin : g_body_r
            assign w_rv   = w_cv[g+1];
            assign w_rk   = w_ck[g+1];
            assign w_rval = w_cval[g+1];
        end

        iokc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_cmp_key     (w_cmp_key),
            .i_left_valid  (w_lv),
            .i_left_key    (w_lk),
            .i_left_value  (w_lval),
            .i_right_valid (w_rv),
            .i_right_key   (w_rk),
            .i_right_value (w_rval),
            .i_seen        (w_seen[g]),
            .o_seen        (w_seen[g+1]),
            .o_match       (w_match[g]),
            .o_valid       (w_cv[g]),
            .o_key         (w_ck[g]),
            .o_value       (w_cval[g])
        );
    end

    // ---------------------------------------------------------------- result
    assign w_hit  = w_seen[CAPACITY];
    assign w_full = (r_count == CNT_W'(CAPACITY));

    // keys are unique, so at most one cell contributes to the and-or select
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_val = w_hit_val | (w_match[i] ? w_cval[i] : '0);
        end
    end
    assign w_hit_val_ext = 64'(w_hit_val);

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        n_out.hit = 1'b0;
        case (t_action'(r_req.action))
            ACT_INSERT: begin
                n_out.hit = w_hit;
                if (!w_hit && w_full) begin
                    // oldest entry falls off the back of the row
                    n_out.evicted     = 1'b1;
                    n_out.evicted_key = 64'(w_ck[CAPACITY-1]);
                end else if (!w_hit) begin
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            ACT_LOOKUP: begin
                n_out.hit       = w_hit;
                n_out.value_out = w_hit_val_ext[31:0];
            end
            ACT_INVALIDATE: begin
                n_out.hit = w_hit;
                if (w_hit) begin
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            default: n_out = '0;
        endcase
        n_out.occupancy = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // count never passes the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // valid cells and the count agree
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cv) == int'(r_count))
        else $error("valid cells disagree with entry count");

    // a key lives in one cell at most
    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC |-> $onehot0(w_match))
        else $error("key matched in more than one cell");

    // valid cells form one run starting at cell 0
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_cv + 1'b1) & w_cv) == '0)
        else $error("gap in the valid cells");

    // an executed word always leaves a result behind
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_valid)
        else $error("executed word without a result");
`endif

endmodule
